// ===== src/tasd_pkg.sv =====
// Shared types and constants of the three-axis step distributor.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package tasd_pkg;

	localparam int MAX_SPAN_DEF   = 64;
	localparam int PASS_LIMIT_DEF = 10;

	// Direction code of one axis in one slot.
	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_POS  = 2'd1,
		DIR_NEG  = 2'd2
	} dir_t;

	// Directions of all three axes in one slot.
	typedef struct packed {
		dir_t center;
		dir_t right;
		dir_t left;
	} slot_t;

	typedef enum logic [2:0] {
		L_IDLE,
		L_SETUP,
		L_DIV,
		L_WALK,
		L_DONE
	} lane_state_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_CALC,
		T_WAIT,
		T_EMIT
	} top_state_t;

endpackage
`default_nettype wire

// ===== src/three_axis_step_distributor.sv =====
// Top level of the three-axis step distributor.
// Depends on tasd_pkg, tasd_lane and tasd_merge.
`default_nettype none
// A request carries target positions of the left, right and centre motors.
// The block subtracts its kept positions, clamps each delta to plus or minus
// MAX_SPAN, and emits one slot request per step of the largest delta, each
// giving the direction of every motor, with tlast on the final slot. A request
// that moves nothing yields no output. Each axis has its own lane, and the
// three lanes plan in parallel; a lane whose axis moves runs one or more
// passes, each made of a bit-serial stride divide and then a walk over the
// span slots, and the slots are emitted once every lane has finished.
// A new request is taken once the last slot has been handed to the output
// register.
module three_axis_step_distributor
	import tasd_pkg::*;
#(
	parameter int MAX_SPAN   = MAX_SPAN_DEF,
	parameter int PASS_LIMIT = PASS_LIMIT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [95:0] s_axis_tdata,  // target_left, target_right, target_center
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // left_dir, right_dir, center_dir, zero fill
	output logic             m_axis_tlast   // last_slot
);

	localparam int W = $clog2(MAX_SPAN + 1);
	localparam logic signed [32:0] SPAN_POS = 33'(MAX_SPAN);
	localparam logic signed [32:0] SPAN_NEG = -33'(MAX_SPAN);

	top_state_t state_q, state_d;
	logic [31:0] tgt_s1 [3];
	logic [31:0] pos_q [3];
	logic [W-1:0] mag_c [3];
	dir_t         code_c [3];
	logic [W-1:0] span_q, span_c, slot_q;
	slot_t        codes_q, merged;
	logic [MAX_SPAN-1:0] taken [3];
	logic [2:0]   done;
	logic         start, load, space, accept;

	assign s_axis_tready = (state_q == T_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;

	// Deltas are formed on 33 bits so that they never wrap, then clamped.
	always_comb begin
		logic signed [32:0] diff, clamped;
		for (int a = 0; a < 3; a++) begin
			diff = 33'(signed'(tgt_s1[a])) - 33'(signed'(pos_q[a]));
			if (diff > SPAN_POS) begin
				clamped = SPAN_POS;
			end else if (diff < SPAN_NEG) begin
				clamped = SPAN_NEG;
			end else begin
				clamped = diff;
			end
			if (clamped < 0) begin
				mag_c[a]  = W'(-clamped);
				code_c[a] = DIR_NEG;
			end else begin
				mag_c[a]  = W'(clamped);
				code_c[a] = (clamped == 0) ? DIR_NONE : DIR_POS;
			end
		end
		span_c = mag_c[0];
		if (mag_c[1] > span_c) span_c = mag_c[1];
		if (mag_c[2] > span_c) span_c = mag_c[2];
	end

	always_comb begin
		state_d = state_q;
		start   = 1'b0;
		load    = 1'b0;
		unique case (state_q)
			T_IDLE: if (accept) state_d = T_CALC;
			T_CALC: begin
				if (span_c == '0) begin
					state_d = T_IDLE;
				end else begin
					start   = 1'b1;
					state_d = T_WAIT;
				end
			end
			T_WAIT: if (&done) state_d = T_EMIT;
			T_EMIT: begin
				load = 1'b1;
				if (space && slot_q == span_q - W'(1)) state_d = T_IDLE;
			end
			default: state_d = T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			for (int a = 0; a < 3; a++) pos_q[a] <= '0;
		end else begin
			state_q <= state_d;
			// Kept positions follow the slots as they enter the output register.
			if (load && space) begin
				unique case (merged.left)
					DIR_POS: pos_q[0] <= pos_q[0] + 32'd1;
					DIR_NEG: pos_q[0] <= pos_q[0] - 32'd1;
					default: pos_q[0] <= pos_q[0];
				endcase
				unique case (merged.right)
					DIR_POS: pos_q[1] <= pos_q[1] + 32'd1;
					DIR_NEG: pos_q[1] <= pos_q[1] - 32'd1;
					default: pos_q[1] <= pos_q[1];
				endcase
				unique case (merged.center)
					DIR_POS: pos_q[2] <= pos_q[2] + 32'd1;
					DIR_NEG: pos_q[2] <= pos_q[2] - 32'd1;
					default: pos_q[2] <= pos_q[2];
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_s1[0] <= s_axis_tdata[31:0];
			tgt_s1[1] <= s_axis_tdata[63:32];
			tgt_s1[2] <= s_axis_tdata[95:64];
		end
		if (state_q == T_CALC) begin
			span_q         <= span_c;
			codes_q.left   <= code_c[0];
			codes_q.right  <= code_c[1];
			codes_q.center <= code_c[2];
			slot_q         <= '0;
		end else if (load && space) begin
			slot_q <= slot_q + W'(1);
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_lane
		tasd_lane #(
			.MAX_SPAN   (MAX_SPAN),
			.PASS_LIMIT (PASS_LIMIT)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (start),
			.steps  (mag_c[a]),
			.span   (span_c),
			.done   (done[a]),
			.taken  (taken[a])
		);
	end

	tasd_merge #(
		.MAX_SPAN (MAX_SPAN)
	) u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.slot          (slot_q),
		.last          (slot_q == span_q - W'(1)),
		.taken_left    (taken[0]),
		.taken_right   (taken[1]),
		.taken_center  (taken[2]),
		.codes         (codes_q),
		.ready         (m_axis_tready),
		.space         (space),
		.merged        (merged),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
`default_nettype wire

// ===== src/tasd_lane.sv =====
// One axis lane: spreads the steps of one axis over the span slots in passes.
// Depends on tasd_pkg; holds its own bit-serial divider for the stride.
`default_nettype none
module tasd_lane
	import tasd_pkg::*;
#(
	parameter int MAX_SPAN   = MAX_SPAN_DEF,
	parameter int PASS_LIMIT = PASS_LIMIT_DEF,
	localparam int W  = $clog2(MAX_SPAN + 1),
	localparam int NW = W + 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [W-1:0]        steps,
	input  wire logic [W-1:0]        span,
	output logic                     done,
	output logic [MAX_SPAN-1:0]      taken
);

	localparam int IW = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
	localparam int PW = $clog2(PASS_LIMIT + 2);
	localparam int CW = $clog2(NW + 1);
	localparam logic [PW-1:0] PASS_SAT = PW'(PASS_LIMIT + 1);

	lane_state_t       state_q, state_d;
	logic [MAX_SPAN-1:0] taken_q, taken_d;
	logic [W-1:0]      rem_q, rem_d, free_q, free_d, local_q, local_d;
	logic [W-1:0]      stride_q, stride_d, cnt_q, cnt_d, idx_q, idx_d, span_q, span_d;
	logic [PW-1:0]     pass_q, pass_d;
	logic [NW-1:0]     num_q, num_d, part_q, part_d, quo_q, quo_d;
	logic [CW-1:0]     bit_q, bit_d;
	logic [NW-1:0]     shifted, quo_n;
	logic              qbit, slot_free;
	logic [W-1:0]      local_n, rem_n, free_n;

	always_comb begin
		state_d  = state_q;
		taken_d  = taken_q;
		rem_d    = rem_q;
		free_d   = free_q;
		local_d  = local_q;
		stride_d = stride_q;
		cnt_d    = cnt_q;
		idx_d    = idx_q;
		span_d   = span_q;
		pass_d   = pass_q;
		num_d    = num_q;
		part_d   = part_q;
		quo_d    = quo_q;
		bit_d    = bit_q;
		shifted  = {part_q[NW-2:0], num_q[NW-1]};
		qbit     = (shifted >= {1'b0, rem_q});
		quo_n    = {quo_q[NW-2:0], qbit};
		slot_free = !taken_q[idx_q[IW-1:0]];
		local_n  = local_q;
		if (slot_free && cnt_q == '0 && local_q < rem_q) begin
			local_n = local_q + W'(1);
		end
		rem_n  = rem_q - local_n;
		free_n = free_q - local_n;
		unique case (state_q)
			L_IDLE, L_DONE: begin
				if (start) begin
					taken_d = '0;
					rem_d   = steps;
					free_d  = span;
					span_d  = span;
					pass_d  = '0;
					state_d = (steps == '0) ? L_DONE : L_SETUP;
				end
			end
			L_SETUP: begin
				// Ceiling stride for the first PASS_LIMIT + 1 passes, floor stride after them.
				if (pass_q == PASS_SAT) begin
					num_d = NW'(free_q);
				end else begin
					num_d = NW'(free_q) + NW'(rem_q) - NW'(1);
				end
				part_d  = '0;
				quo_d   = '0;
				bit_d   = '0;
				state_d = L_DIV;
			end
			L_DIV: begin
				part_d = qbit ? (shifted - {1'b0, rem_q}) : shifted;
				num_d  = {num_q[NW-2:0], 1'b0};
				quo_d  = quo_n;
				bit_d  = bit_q + CW'(1);
				if (bit_q == CW'(NW - 1)) begin
					stride_d = (quo_n == '0) ? W'(1) : quo_n[W-1:0];
					idx_d    = '0;
					cnt_d    = '0;
					local_d  = '0;
					state_d  = L_WALK;
				end
			end
			L_WALK: begin
				if (slot_free) begin
					if (cnt_q == '0) begin
						if (local_q < rem_q) begin
							taken_d[idx_q[IW-1:0]] = 1'b1;
						end
						cnt_d = stride_q - W'(1);
					end else begin
						cnt_d = cnt_q - W'(1);
					end
				end
				local_d = local_n;
				idx_d   = idx_q + W'(1);
				if (idx_q == span_q - W'(1)) begin
					rem_d  = rem_n;
					free_d = free_n;
					if (pass_q != PASS_SAT) begin
						pass_d = pass_q + PW'(1);
					end
					state_d = (rem_n == '0 || free_n == '0) ? L_DONE : L_SETUP;
				end
			end
			default: state_d = L_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		taken_q  <= taken_d;
		rem_q    <= rem_d;
		free_q   <= free_d;
		local_q  <= local_d;
		stride_q <= stride_d;
		cnt_q    <= cnt_d;
		idx_q    <= idx_d;
		span_q   <= span_d;
		pass_q   <= pass_d;
		num_q    <= num_d;
		part_q   <= part_d;
		quo_q    <= quo_d;
		bit_q    <= bit_d;
	end

	assign done  = (state_q == L_DONE);
	assign taken = taken_q;

endmodule
`default_nettype wire

// ===== src/tasd_merge.sv =====
// Merging stage: combines the three lane masks into one slot request and
// holds it in the output register. Depends on tasd_pkg.
`default_nettype none
module tasd_merge
	import tasd_pkg::*;
#(
	parameter int MAX_SPAN = MAX_SPAN_DEF,
	localparam int W = $clog2(MAX_SPAN + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire logic [W-1:0]        slot,
	input  wire logic                last,
	input  wire logic [MAX_SPAN-1:0] taken_left,
	input  wire logic [MAX_SPAN-1:0] taken_right,
	input  wire logic [MAX_SPAN-1:0] taken_center,
	input  wire slot_t               codes,
	input  wire logic                ready,
	output logic                     space,
	output slot_t                    merged,
	output logic                     m_axis_tvalid,
	output logic [7:0]               m_axis_tdata,  // left_dir, right_dir, center_dir, 0
	output logic                     m_axis_tlast
);

	localparam int IW = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;

	logic  valid_q;
	slot_t data_q;
	logic  last_q;

	always_comb begin
		merged.left   = taken_left[slot[IW-1:0]]   ? codes.left   : DIR_NONE;
		merged.right  = taken_right[slot[IW-1:0]]  ? codes.right  : DIR_NONE;
		merged.center = taken_center[slot[IW-1:0]] ? codes.center : DIR_NONE;
	end

	assign space = !valid_q || ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (space && load) begin
			data_q <= merged;
			last_q <= last;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {2'b00, data_q.center, data_q.right, data_q.left};
	assign m_axis_tlast  = last_q;

endmodule
`default_nettype wire
